// ===== hw/rtl/imuoct_pkg.sv =====
// ----------------------------------------------------------------------------
// imuoct_pkg
// Shared types and constants for the IMU offset calibration and tilt block.
// ----------------------------------------------------------------------------
package imuoct_pkg;

    localparam int AXES            = 6;
    localparam int RAW_W           = 16;
    localparam int COR_W           = 17;
    localparam int ANG_W           = 16;
    localparam int SUM_W           = 28;
    localparam int CNT_W           = 12;
    localparam int MAX_CAL_SAMPLES = 4095;
    localparam int CAL_RESET       = 2000;
    localparam int ONE_G           = 4096;
    localparam int ANGLE_LIMIT     = 23040;
    localparam int CW              = 45;      // CORDIC x/y width
    localparam int AW              = 25;      // angle accumulator, 1/65536 deg
    localparam int PRE_SHIFT       = 24;
    localparam int QUARTER_TURN    = 5898240;
    localparam int STEP_LIMIT      = 24;
    localparam int DIV_BITS        = SUM_W;
    localparam int SQRT_STEPS      = 17;
    localparam int AXIS_IDX_W      = 3;

    // atan(2^-i) in 1/65536 degree
    localparam logic [22:0] ATAN_TAB [STEP_LIMIT] = '{
        23'd2949120, 23'd1740967, 23'd919879, 23'd466945,
        23'd234379,  23'd117304,  23'd58666,  23'd29335,
        23'd14668,   23'd7334,    23'd3667,   23'd1833,
        23'd917,     23'd458,     23'd229,    23'd115,
        23'd57,      23'd29,      23'd14,     23'd7,
        23'd4,       23'd2,       23'd1,      23'd0
    };

    typedef struct packed {
        logic                 valid;
        logic                 is_pitch;
        logic                 zero;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [AW-1:0] acc;
    } t_cordic;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DLOAD,
        ST_DIV,
        ST_SQ,
        ST_SQRT,
        ST_PITCH,
        ST_DRAIN,
        ST_DONE
    } t_state;

endpackage

// ===== hw/rtl/imuoct_axis_cell.sv =====
// ----------------------------------------------------------------------------
// imuoct_axis_cell
// One axis: calibration sum, stored offset and saturated correction.
// ----------------------------------------------------------------------------
module imuoct_axis_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic signed [imuoct_pkg::RAW_W-1:0] i_raw,
    input  logic                                i_acc_en,
    input  logic                                i_off_we,
    input  logic signed [imuoct_pkg::COR_W-1:0] i_off,
    output logic signed [imuoct_pkg::SUM_W-1:0] o_sum,
    output logic signed [imuoct_pkg::COR_W-1:0] o_cor
);
    import imuoct_pkg::*;

    logic signed [SUM_W-1:0] r_sum;
    logic signed [COR_W-1:0] r_off;
    logic signed [COR_W:0]   diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_off <= '0;
        end else begin
            if (i_acc_en) begin
                r_sum <= r_sum + SUM_W'(i_raw);
            end
            if (i_off_we) begin
                r_off <= i_off;
            end
        end
    end

    always_comb begin
        diff = (COR_W+1)'(i_raw) - (COR_W+1)'(r_off);
        if (diff > (COR_W+1)'(65535)) begin
            o_cor = COR_W'(65535);
        end else if (diff < -(COR_W+1)'(65536)) begin
            o_cor = -COR_W'(65536);
        end else begin
            o_cor = diff[COR_W-1:0];
        end
    end

    assign o_sum = r_sum;

endmodule

// ===== hw/rtl/imuoct_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// imuoct_cordic_cell
// One vectoring step of the CORDIC chain with a fixed shift.
// ----------------------------------------------------------------------------
module imuoct_cordic_cell #(
    parameter int SHIFT = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  imuoct_pkg::t_cordic i_stage,
    output imuoct_pkg::t_cordic o_stage
);
    import imuoct_pkg::*;

    t_cordic              r_stage;
    t_cordic              n_stage;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [AW-1:0] dang;

    always_comb begin
        dx      = i_stage.y >>> SHIFT;
        dy      = i_stage.x >>> SHIFT;
        dang    = $signed({2'b00, ATAN_TAB[SHIFT]});
        n_stage = i_stage;
        if (!i_stage.y[CW-1]) begin
            n_stage.x   = i_stage.x + dx;
            n_stage.y   = i_stage.y - dy;
            n_stage.acc = i_stage.acc + dang;
        end else begin
            n_stage.x   = i_stage.x - dx;
            n_stage.y   = i_stage.y + dy;
            n_stage.acc = i_stage.acc - dang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

// ===== hw/rtl/imu_offset_calibration_and_tilt.sv =====
// ----------------------------------------------------------------------------
// imu_offset_calibration_and_tilt
// IMU bias calibration, offset correction and accelerometer roll/pitch.
// ----------------------------------------------------------------------------
// After reset the first cal_samples transfers are summed per axis and
// produce no output. The offsets are then computed once by a shared
// radix-2 divider, one axis at a time, while no transfer is taken. Every
// later sample takes a squaring step, the bit-serial square root for the
// pitch denominator, then the pitch vector passing the row of CORDIC_STEPS
// cells. The roll vector goes through the cells while the square root runs.
// A finished result sits in the output register so the next sample can be
// accepted while it waits.
module imu_offset_calibration_and_tilt #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // raw_acc_x, raw_acc_y, raw_acc_z, raw_gyro_x, raw_gyro_y, raw_gyro_z
    input  logic [95:0]  i_s_axis_tdata,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // acc_x_corrected, acc_y_corrected, acc_z_corrected, roll_rate,
    // pitch_rate, yaw_rate, roll_angle, pitch_angle, 2 zero pad bits
    output logic [135:0] o_m_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    input  logic         i_cfg_wr_en,
    input  logic [11:0]  i_cfg_wr_data
);
    import imuoct_pkg::*;

    t_state r_state, n_state;

    logic [CNT_W-1:0] r_cal_samples;
    logic             r_calibrating;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] target;

    logic in_fire;
    logic out_free;

    logic signed [RAW_W-1:0] raw     [AXES];
    logic signed [SUM_W-1:0] sums    [AXES];
    logic signed [COR_W-1:0] cor     [AXES];
    logic signed [COR_W-1:0] r_cor   [AXES];
    logic                    off_we  [AXES];
    logic signed [COR_W-1:0] off_val;

    // divider
    logic [AXIS_IDX_W-1:0]   r_axis;
    logic [SUM_W-1:0]        r_div_num;
    logic [CNT_W:0]          r_div_rem;
    logic [4:0]              r_div_cnt;
    logic                    r_div_neg;
    logic [CNT_W:0]          rem_sh;
    logic                    div_ge;
    logic [SUM_W-1:0]        quot;
    logic signed [SUM_W-1:0] sum_sel;
    logic [SUM_W-1:0]        sum_mag;
    logic                    div_last;

    // square root
    logic [33:0]             r_rad;
    logic [SQRT_STEPS-1:0]   r_root;
    logic [17:0]             r_srem;
    logic [4:0]              r_sq_cnt;
    logic [19:0]             rem4;
    logic [19:0]             trial;
    logic                    sq_ge;

    // cordic chain
    t_cordic                 chain [CORDIC_STEPS+1];
    logic signed [17:0]      ent_x18;
    logic signed [17:0]      ent_y18;
    logic signed [CW-1:0]    xs;
    logic signed [CW-1:0]    ys;
    logic signed [AW-1:0]    rnd;
    logic signed [AW-1:0]    shd;
    logic signed [ANG_W-1:0] ang;
    logic signed [ANG_W-1:0] r_roll;
    logic signed [ANG_W-1:0] r_pitch;

    logic         r_out_valid;
    logic [135:0] r_out_data;

    assign in_fire  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign n_count  = r_count + 1'b1;

    always_comb begin
        if (r_cal_samples == '0) begin
            target = CNT_W'(1);
        end else if (int'(r_cal_samples) > MAX_CAL_SAMPLES) begin
            target = CNT_W'(MAX_CAL_SAMPLES);
        end else begin
            target = r_cal_samples;
        end
    end

    // ---------------- axis cells ----------------
    for (genvar k = 0; k < AXES; k++) begin : g_axis
        assign raw[k]    = $signed(i_s_axis_tdata[RAW_W*k +: RAW_W]);
        assign off_we[k] = div_last && (r_axis == AXIS_IDX_W'(k));
        imuoct_axis_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_raw    (raw[k]),
            .i_acc_en (in_fire && r_calibrating),
            .i_off_we (off_we[k]),
            .i_off    (off_val),
            .o_sum    (sums[k]),
            .o_cor    (cor[k])
        );
    end

    // ---------------- divider datapath ----------------
    always_comb begin
        sum_sel = sums[0];
        case (r_axis)
            3'd1:    sum_sel = sums[1];
            3'd2:    sum_sel = sums[2];
            3'd3:    sum_sel = sums[3];
            3'd4:    sum_sel = sums[4];
            3'd5:    sum_sel = sums[5];
            default: sum_sel = sums[0];
        endcase
        sum_mag  = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
        rem_sh   = {r_div_rem[CNT_W-1:0], r_div_num[SUM_W-1]};
        div_ge   = rem_sh >= {1'b0, r_count};
        quot     = {r_div_num[SUM_W-2:0], div_ge};
        div_last = (r_state == ST_DIV) && (r_div_cnt == 5'(DIV_BITS-1));
        off_val  = r_div_neg ? -$signed(quot[COR_W-1:0]) : $signed(quot[COR_W-1:0]);
        if (r_axis == AXIS_IDX_W'(2)) begin
            off_val = off_val - COR_W'(ONE_G);
        end
    end

    // ---------------- square root step ----------------
    always_comb begin
        rem4  = {r_srem, r_rad[33:32]};
        trial = {1'b0, r_root, 2'b01};
        sq_ge = rem4 >= trial;
    end

    // ---------------- cordic entry ----------------
    always_comb begin
        if (r_state == ST_PITCH) begin
            ent_y18 = -(18'(r_cor[0]));
            ent_x18 = $signed({1'b0, r_root});
        end else begin
            ent_y18 = 18'(r_cor[1]);
            ent_x18 = 18'(r_cor[2]);
        end
        xs = CW'(ent_x18) <<< PRE_SHIFT;
        ys = CW'(ent_y18) <<< PRE_SHIFT;
        chain[0].valid    = (r_state == ST_SQ) || (r_state == ST_PITCH);
        chain[0].is_pitch = (r_state == ST_PITCH);
        chain[0].zero     = (ent_x18 == '0) && (ent_y18 == '0);
        chain[0].x        = xs;
        chain[0].y        = ys;
        chain[0].acc      = '0;
        if (xs[CW-1]) begin
            if (!ys[CW-1]) begin
                chain[0].x   = ys;
                chain[0].y   = -xs;
                chain[0].acc = AW'(QUARTER_TURN);
            end else begin
                chain[0].x   = -ys;
                chain[0].y   = xs;
                chain[0].acc = -AW'(QUARTER_TURN);
            end
        end
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        imuoct_cordic_cell #(.SHIFT(g)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (chain[g]),
            .o_stage (chain[g+1])
        );
    end

    always_comb begin
        rnd = chain[CORDIC_STEPS].acc + AW'(128);
        shd = rnd >>> 8;
        if (chain[CORDIC_STEPS].zero) begin
            ang = '0;
        end else if (shd > AW'(ANGLE_LIMIT)) begin
            ang = ANG_W'(ANGLE_LIMIT);
        end else if (shd < -AW'(ANGLE_LIMIT)) begin
            ang = -ANG_W'(ANGLE_LIMIT);
        end else begin
            ang = shd[ANG_W-1:0];
        end
    end

    // ---------------- control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (in_fire) begin
                    if (!r_calibrating) begin
                        n_state = ST_SQ;
                    end else if (n_count >= target) begin
                        n_state = ST_DLOAD;
                    end
                end
            end
            ST_DLOAD: n_state = ST_DIV;
            ST_DIV: begin
                if (div_last) begin
                    n_state = (r_axis == AXIS_IDX_W'(AXES-1)) ? ST_IDLE : ST_DLOAD;
                end
            end
            ST_SQ:    n_state = ST_SQRT;
            ST_SQRT: begin
                if (r_sq_cnt == 5'(SQRT_STEPS-1)) begin
                    n_state = ST_PITCH;
                end
            end
            ST_PITCH: n_state = ST_DRAIN;
            ST_DRAIN: begin
                if (chain[CORDIC_STEPS].valid && chain[CORDIC_STEPS].is_pitch) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_samples <= CNT_W'(CAL_RESET);
            r_calibrating <= 1'b1;
            r_count       <= '0;
            r_axis        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cal_samples <= i_cfg_wr_data;
            end
            if (in_fire && r_calibrating) begin
                r_count <= n_count;
                r_axis  <= '0;
            end
            if (div_last) begin
                r_axis <= r_axis + 1'b1;
                if (r_axis == AXIS_IDX_W'(AXES-1)) begin
                    r_calibrating <= 1'b0;
                end
            end
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            for (int k = 0; k < AXES; k++) begin
                r_cor[k] <= cor[k];
            end
        end
        case (r_state)
            ST_DLOAD: begin
                r_div_num <= sum_mag + SUM_W'(r_count >> 1);
                r_div_rem <= '0;
                r_div_cnt <= '0;
                r_div_neg <= sum_sel[SUM_W-1];
            end
            ST_DIV: begin
                r_div_num <= quot;
                r_div_rem <= div_ge ? rem_sh - {1'b0, r_count} : rem_sh;
                r_div_cnt <= r_div_cnt + 1'b1;
            end
            ST_SQ: begin
                r_rad    <= $unsigned(34'(r_cor[1]) * 34'(r_cor[1]))
                          + $unsigned(34'(r_cor[2]) * 34'(r_cor[2]));
                r_root   <= '0;
                r_srem   <= '0;
                r_sq_cnt <= '0;
            end
            ST_SQRT: begin
                r_rad    <= {r_rad[31:0], 2'b00};
                r_srem   <= sq_ge ? 18'(rem4 - trial) : 18'(rem4);
                r_root   <= {r_root[SQRT_STEPS-2:0], sq_ge};
                r_sq_cnt <= r_sq_cnt + 1'b1;
            end
            ST_DONE: begin
                if (out_free) begin
                    r_out_data <= {2'b00, r_pitch, r_roll, r_cor[5], r_cor[4],
                                   r_cor[3], r_cor[2], r_cor[1], r_cor[0]};
                end
            end
            default: ;
        endcase
        if (chain[CORDIC_STEPS].valid) begin
            if (chain[CORDIC_STEPS].is_pitch) begin
                r_pitch <= ang;
            end else begin
                r_roll <= ang;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// ===== hw/rtl/imuoct_checker.sv =====
// ----------------------------------------------------------------------------
// imuoct_checker
// Port-level checks for the IMU calibration and tilt block.
// ----------------------------------------------------------------------------
module imuoct_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic [135:0] o_m_axis_tdata,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready
);

    // no result may appear right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled output changed");

    // both angles stay within +-90 degrees
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ($signed(o_m_axis_tdata[117:102]) <= 16'sd23040) &&
            ($signed(o_m_axis_tdata[117:102]) >= -16'sd23040) &&
            ($signed(o_m_axis_tdata[133:118]) <= 16'sd23040) &&
            ($signed(o_m_axis_tdata[133:118]) >= -16'sd23040))
        else $error("angle out of range");

    // a new result never shows up in the cycle right after an input transfer
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !$rose(o_m_axis_tvalid))
        else $error("result right after input transfer");

    // padding bits are always zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[135:134] == 2'b00)
        else $error("output padding not zero");

endmodule

bind imu_offset_calibration_and_tilt imuoct_checker u_imuoct_checker (.*);

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for imu_offset_calibration_and_tilt. Drives raw
// six-axis samples with random gaps, checks every corrected sample and the
// roll/pitch angles against an in-bench calibration and CORDIC predictor.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import imuoct_pkg::*;

    localparam int STEPS       = 16;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [15:0] gz;
        logic [15:0] gy;
        logic [15:0] gx;
        logic [15:0] az;
        logic [15:0] ay;
        logic [15:0] ax;
    } t_sample;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic [95:0]  i_s_axis_tdata = '0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [135:0] o_m_axis_tdata;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic         i_cfg_wr_en = 1'b0;
    logic [11:0]  i_cfg_wr_data = '0;

    // stimulus / expectation stores
    t_sample        pending_samples[$];
    logic [135:0]   expected_outputs[$];
    int             n_pushed = 0;
    int             n_accepted = 0;
    int             n_results = 0;
    int             n_fail = 0;
    int             cycles = 0;
    bit             gaps_on = 1'b1;
    bit             rx_hold = 1'b0;

    // predictor state
    logic [11:0]    cal_reg = 12'(CAL_RESET);
    bit             calibrating = 1'b1;
    int             cal_count = 0;
    longint         axis_sum[AXES] = '{default: 0};
    longint         axis_off[AXES] = '{default: 0};

    imu_offset_calibration_and_tilt #(.CORDIC_STEPS(STEPS)) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint sat_cor(longint v);
        if (v > 65535) return 65535;
        if (v < -65536) return -65536;
        return v;
    endfunction

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned res = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // atan2(y, x) in 1/256 degree, clamped to +-90
    function automatic longint tilt_angle(longint y, longint x);
        longint acc = 0;
        longint t, dx, dy;
        if (x == 0 && y == 0) return 0;
        x = x * 16777216;
        y = y * 16777216;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; acc = QUARTER_TURN;
            end else begin
                t = x; x = -y; y = t; acc = -QUARTER_TURN;
            end
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; acc += longint'(ATAN_TAB[i]);
            end else begin
                x -= dx; y += dy; acc -= longint'(ATAN_TAB[i]);
            end
        end
        acc = (acc + 128) >>> 8;
        if (acc > ANGLE_LIMIT) acc = ANGLE_LIMIT;
        if (acc < -ANGLE_LIMIT) acc = -ANGLE_LIMIT;
        return acc;
    endfunction

    // calibration accumulate, or correction plus tilt for one accepted sample
    task automatic predict_sample(t_sample s);
        longint raw[AXES];
        longint cor[AXES];
        longint target, n, m, q, r;
        logic [135:0] res;
        raw[0] = longint'($signed(s.ax)); raw[1] = longint'($signed(s.ay));
        raw[2] = longint'($signed(s.az)); raw[3] = longint'($signed(s.gx));
        raw[4] = longint'($signed(s.gy)); raw[5] = longint'($signed(s.gz));
        if (calibrating) begin
            target = (cal_reg == 0) ? 1 : longint'(cal_reg);
            for (int k = 0; k < AXES; k++) axis_sum[k] += raw[k];
            cal_count++;
            if (cal_count >= target) begin
                n = cal_count;
                for (int k = 0; k < AXES; k++) begin
                    m = (axis_sum[k] < 0) ? -axis_sum[k] : axis_sum[k];
                    q = (m + n / 2) / n;
                    axis_off[k] = (axis_sum[k] < 0) ? -q : q;
                end
                axis_off[2] -= ONE_G;
                calibrating = 1'b0;
            end
            return;
        end
        for (int k = 0; k < AXES; k++) cor[k] = sat_cor(raw[k] - axis_off[k]);
        r = longint'(floor_root(longint'(cor[1] * cor[1]) + longint'(cor[2] * cor[2])));
        res = '0;
        for (int k = 0; k < AXES; k++) res[k*17 +: 17] = cor[k][16:0];
        res[102 +: 16] = 16'(tilt_angle(cor[1], cor[2]));
        res[118 +: 16] = 16'(tilt_angle(-cor[0], r));
        expected_outputs.push_back(res);
    endtask

    // sender
    always @(posedge i_clk) begin
        t_sample nxt;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                predict_sample(t_sample'(i_s_axis_tdata));
                n_accepted++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (pending_samples.size() > 0 &&
                    !(gaps_on && $urandom_range(99) < 16)) begin
                    nxt = pending_samples.pop_front();
                    i_s_axis_tdata  <= nxt;
                    i_s_axis_tvalid <= 1'b1;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver, checker and watchdog
    always @(posedge i_clk) begin
        logic [135:0] want;
        int lsb, w;
        string fname[8];
        fname = '{"acc_x_corrected", "acc_y_corrected", "acc_z_corrected",
                  "roll_rate", "pitch_rate", "yaw_rate", "roll_angle",
                  "pitch_angle"};
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                n_results++;
                if (expected_outputs.size() == 0) begin
                    $error("result transfer with nothing expected");
                    n_fail++;
                end else begin
                    want = expected_outputs.pop_front();
                    for (int k = 0; k < 8; k++) begin
                        lsb = (k < 6) ? k * 17 : 102 + (k - 6) * 16;
                        w   = (k < 6) ? 17 : 16;
                        if (((want ^ o_m_axis_tdata) >> lsb) & ((136'd1 << w) - 1)) begin
                            $error("%s: expected %h, got %h", fname[k],
                                   (want >> lsb) & ((136'd1 << w) - 1),
                                   (o_m_axis_tdata >> lsb) & ((136'd1 << w) - 1));
                            n_fail++;
                        end
                    end
                end
            end
            i_m_axis_tready <= !rx_hold && !(gaps_on && $urandom_range(99) < 16);
        end
    end

    // long receiver stall so the block backs up into its input
    initial begin
        while (n_results < 40) @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (500) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    // stretch with no gaps on either side
    initial begin
        while (n_results < 300) @(posedge i_clk);
        gaps_on = 1'b0;
        repeat (3000) @(posedge i_clk);
        gaps_on = 1'b1;
    end

    task automatic write_cal(logic [11:0] v);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        cal_reg = v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    task automatic push(t_sample s);
        pending_samples.push_back(s);
        n_pushed++;
    endtask

    task automatic wait_drained();
        while (n_accepted != n_pushed || expected_outputs.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_axis(longint off);
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3, 4, 5: return 16'(off + longint'($urandom_range(16384)) - 8192);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_random(int count);
        t_sample s;
        repeat (count) begin
            s.ax = pick_axis(axis_off[0]); s.ay = pick_axis(axis_off[1]);
            s.az = pick_axis(axis_off[2]); s.gx = pick_axis(axis_off[3]);
            s.gy = pick_axis(axis_off[4]); s.gz = pick_axis(axis_off[5]);
            push(s);
        end
    endtask

    function automatic t_sample at_offsets(longint dx, longint dy, longint dz);
        t_sample s;
        s.ax = 16'(axis_off[0] + dx); s.ay = 16'(axis_off[1] + dy);
        s.az = 16'(axis_off[2] + dz); s.gx = 16'(axis_off[3]);
        s.gy = 16'(axis_off[4]);      s.gz = 16'(axis_off[5]);
        return s;
    endfunction

    initial begin
        t_sample s;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_cal(12'd4095);
        write_cal(12'd0);
        write_cal(12'd5);

        // calibration: z near -15904 puts the z offset at -20000
        repeat (3) begin
            s.ax = 16'($urandom_range(6000) - 3000);
            s.ay = 16'($urandom_range(6000) - 3000);
            s.az = 16'(-15904);
            s.gx = 16'($urandom); s.gy = 16'($urandom); s.gz = 16'($urandom);
            push(s);
        end
        wait_drained();
        repeat (30) @(posedge i_clk);
        // lowering the count below what was seen ends calibration on the next sample
        write_cal(12'd2);
        s.ax = 16'($urandom_range(6000) - 3000);
        s.ay = 16'($urandom_range(6000) - 3000);
        s.az = 16'(-15904);
        s.gx = 16'($urandom); s.gy = 16'($urandom); s.gz = 16'($urandom);
        push(s);
        wait_drained();
        repeat (400) @(posedge i_clk);

        // directed
        push(at_offsets(0, 0, 0));            // zero vector
        push(at_offsets(-500, 0, 0));         // zero roll vector, pitch only
        push(at_offsets(0, 1000, 0));
        push(at_offsets(0, -1000, 0));
        push(at_offsets(300, 1000, -4000));   // az < 0, ay >= 0
        push(at_offsets(-300, -1000, -4000)); // az < 0, ay < 0
        push(at_offsets(0, 0, -4000));
        push(at_offsets(4096, 0, 4096));
        push(at_offsets(-4096, 0, 4096));
        push(at_offsets(0, 0, 4096));
        push(96'h7FFF_7FFF_7FFF_7FFF_7FFF_7FFF);
        push(96'h8000_8000_8000_8000_8000_8000);
        push(96'h0);
        push(96'hFFFF_FFFF_FFFF_FFFF_FFFF_FFFF);
        push(96'h8000_7FFF_8000_7FFF_8000_7FFF);
        push(96'h7FFF_8000_7FFF_8000_7FFF_8000);
        wait_drained();
        repeat (60) @(posedge i_clk);
        write_cal(12'd0);

        push_random(500);
        wait_drained();
        repeat (60) @(posedge i_clk);
        write_cal(12'd4095);
        push_random(500);
        // wait until every sample is accepted and every result is back
        wait_drained();
        write_cal(12'd2000);
        push_random(30);
        wait_drained();
        repeat (200) @(posedge i_clk);

        if (expected_outputs.size() != 0) n_fail++;
        if (n_fail == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
